>>> src/thumb_alu_execute_core_assert.svh
// assertion macros for the thumb execute core
// no dependencies beyond the including module's clock and reset names
`ifndef THUMB_ALU_EXECUTE_CORE_ASSERT_SVH
`define THUMB_ALU_EXECUTE_CORE_ASSERT_SVH

`define TAE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`define TAE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/tae_pkg.sv
// types and constants for the thumb execute core
// no dependencies
package tae_pkg;

   typedef struct packed {
      logic [15:0] instruction;
      logic [31:0] rs_value;
      logic [31:0] rd_value;
      logic [31:0] rn_value;
      logic [31:0] pc_value;
      logic [31:0] sp_value;
      logic        carry_in;
      logic        overflow_in;
      logic        negative_in;
      logic        zero_in;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic [3:0]  dest_reg;
      logic        write_en;
      logic        negative_out;
      logic        zero_out;
      logic        carry_out;
      logic        overflow_out;
      logic        enter_arm_state;
      logic [31:0] next_pc;
      logic        not_handled;
   } rsp_type;

   typedef enum logic [2:0] {
      FMT_ADDSUB, FMT_SHIFT, FMT_IMM8, FMT_ALU, FMT_HIREG, FMT_ADDR, FMT_NONE
   } fmt_type;

   // per-item operation after decode
   typedef enum logic [2:0] {
      K_ADD, K_LOGIC, K_SHIFT, K_MUL, K_MOVB, K_BX, K_ADDR, K_NONE
   } kind_type;

   typedef enum logic [1:0] {
      LOG_AND, LOG_EOR, LOG_ORR, LOG_BIC
   } logic_op_type;

   typedef enum logic [1:0] {
      SH_LSL, SH_LSR, SH_ASR, SH_ROR
   } shift_op_type;

   localparam logic [3:0] ALU_AND = 4'h0, ALU_EOR = 4'h1, ALU_LSL = 4'h2, ALU_LSR = 4'h3,
      ALU_ASR = 4'h4, ALU_ADC = 4'h5, ALU_SBC = 4'h6, ALU_ROR = 4'h7, ALU_TST = 4'h8,
      ALU_NEG = 4'h9, ALU_CMP = 4'hA, ALU_CMN = 4'hB, ALU_ORR = 4'hC, ALU_MUL = 4'hD,
      ALU_BIC = 4'hE, ALU_MVN = 4'hF;

   localparam logic [3:0] PC_REG = 4'd15;

   // decoded item carried from stage 1
   typedef struct packed {
      kind_type     kind;
      logic [31:0]  a;
      logic [31:0]  b;
      logic         cin;
      logic         set_nz;
      logic         set_cv;
      logic_op_type lop;
      shift_op_type sop;
      logic [7:0]   amt;
      logic [3:0]   dst;
      logic         we;
      logic [31:0]  pc2;
      logic         n0, z0, c0, v0;
   } dec_type;

   // executed item carried from stage 2
   typedef struct packed {
      kind_type    kind;
      logic [31:0] res;
      logic        set_nz;
      logic        c, v;
      logic [3:0]  dst;
      logic        we;
      logic [31:0] pc2;
      logic        n0, z0;
      logic [31:0] ma, mb;
   } exe_type;

endpackage

>>> src/thumb_alu_execute_core.sv
// each req beat passes through the decode, execute, multiply and flag stages to its rsp beat
// throughput: one instruction per cycle; a stall on rsp holds every stage
// the 32x32 multiply is split over multiply and flag stages as 16-bit partial products
// reset clears the stage valid bits only; payload registers are not reset
// depends on tae_pkg, tae_decode and the assertion macro header
`include "thumb_alu_execute_core_assert.svh"
module thumb_alu_execute_core
   import tae_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic    adv;
   dec_type dec_in, d_ff;
   exe_type e_in, e_ff;
   exe_type m_in, m_ff;
   rsp_type r_in, r_ff;

   logic [32:0] sum;
   logic [31:0] sh_res;
   logic        sh_c;
   logic [31:0] p_ll, p_lh, p_hl;
   logic [31:0] res;
   logic [4:0]  rn;

   // whole pipe moves together
   assign adv       = !v4_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = v4_ff;
   assign rsp_data  = r_ff;

   tae_decode u_dec (.req(req_data), .dec(dec_in));

   always_comb begin
      sum    = {1'b0, d_ff.a} + {1'b0, d_ff.b} + {32'd0, d_ff.cin};
      sh_res = d_ff.a;
      sh_c   = d_ff.c0;
      rn     = d_ff.amt[4:0];
      if (d_ff.amt != 8'd0) begin
         case (d_ff.sop)
            SH_LSL: begin
               if (d_ff.amt < 8'd32) begin
                  sh_res = d_ff.a << d_ff.amt[4:0];
                  sh_c = d_ff.a[5'd0 - d_ff.amt[4:0]];
               end else begin
                  sh_res = '0; sh_c = (d_ff.amt == 8'd32) ? d_ff.a[0] : 1'b0;
               end
            end
            SH_LSR: begin
               if (d_ff.amt < 8'd32) begin
                  sh_res = d_ff.a >> d_ff.amt[4:0];
                  sh_c = d_ff.a[d_ff.amt[4:0] - 5'd1];
               end else begin
                  sh_res = '0; sh_c = (d_ff.amt == 8'd32) ? d_ff.a[31] : 1'b0;
               end
            end
            SH_ASR: begin
               if (d_ff.amt < 8'd32) begin
                  sh_res = 32'($signed(d_ff.a) >>> d_ff.amt[4:0]);
                  sh_c = d_ff.a[d_ff.amt[4:0] - 5'd1];
               end else begin
                  sh_res = {32{d_ff.a[31]}}; sh_c = d_ff.a[31];
               end
            end
            default: begin
               if (rn == 5'd0) sh_c = d_ff.a[31];
               else begin
                  sh_res = (d_ff.a >> rn) | (d_ff.a << (6'd32 - {1'b0, rn}));
                  sh_c = d_ff.a[rn - 5'd1];
               end
            end
         endcase
      end
      e_in        = '0;
      e_in.kind   = d_ff.kind;
      e_in.set_nz = d_ff.set_nz;
      e_in.dst    = d_ff.dst;
      e_in.we     = d_ff.we;
      e_in.pc2    = d_ff.pc2;
      e_in.n0     = d_ff.n0;
      e_in.z0     = d_ff.z0;
      e_in.c      = d_ff.c0;
      e_in.v      = d_ff.v0;
      e_in.ma     = d_ff.a;
      e_in.mb     = d_ff.b;
      case (d_ff.kind) inside
         K_ADD, K_ADDR: begin
            e_in.res = sum[31:0];
            if (d_ff.set_cv) begin
               e_in.c = sum[32];
               e_in.v = (d_ff.a[31] ^ sum[31]) & (d_ff.b[31] ^ sum[31]);
            end
         end
         K_LOGIC: begin
            case (d_ff.lop)
               LOG_AND: e_in.res = d_ff.a & d_ff.b;
               LOG_EOR: e_in.res = d_ff.a ^ d_ff.b;
               LOG_ORR: e_in.res = d_ff.a | d_ff.b;
               default: e_in.res = d_ff.a & ~d_ff.b;
            endcase
         end
         K_SHIFT: begin e_in.res = sh_res; e_in.c = sh_c; end
         K_MOVB, K_BX: e_in.res = d_ff.b;
         default: e_in.res = '0;
      endcase
   end

   // multiply: three 16x16 partial products, low 32 bits only
   always_comb begin
      p_ll = e_ff.ma[15:0] * e_ff.mb[15:0];
      p_lh = e_ff.ma[15:0] * e_ff.mb[31:16];
      p_hl = e_ff.ma[31:16] * e_ff.mb[15:0];
      m_in = e_ff;
      if (e_ff.kind == K_MUL) begin
         m_in.ma = p_ll;
         m_in.mb = {p_lh[15:0] + p_hl[15:0], 16'd0};
      end
   end

   always_comb begin
      res = (m_ff.kind == K_MUL) ? m_ff.ma + m_ff.mb : m_ff.res;
      r_in = '0;
      r_in.dest_reg     = m_ff.dst;
      r_in.write_en     = m_ff.we;
      r_in.negative_out = m_ff.set_nz ? res[31] : m_ff.n0;
      r_in.zero_out     = m_ff.set_nz ? (res == 32'd0) : m_ff.z0;
      r_in.carry_out    = m_ff.c;
      r_in.overflow_out = m_ff.v;
      r_in.next_pc      = m_ff.pc2;
      case (m_ff.kind)
         K_NONE: begin
            r_in.not_handled = 1'b1; r_in.dest_reg = '0; r_in.write_en = 1'b0;
         end
         K_BX: begin
            r_in.result_value    = {res[31:1], 1'b0};
            r_in.next_pc         = {res[31:1], 1'b0};
            r_in.enter_arm_state = !res[0];
         end
         default: begin
            r_in.result_value = res;
            if (m_ff.we && m_ff.dst == PC_REG) r_in.next_pc = {res[31:1], 1'b0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= dec_in; e_ff <= e_in; m_ff <= m_in; r_ff <= r_in;
      end
   end

   `TAE_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `TAE_ASSERT_NEXT(a_req_flow, req_valid && req_ready, v1_ff)
   `TAE_ASSERT_IMP(a_ready_free, !v4_ff, req_ready)
   `TAE_ASSERT_IMP(a_bx_nowrite, rsp_valid && rsp_data.enter_arm_state, !rsp_data.write_en)

endmodule

>>> src/tae_decode.sv
// instruction decode and operand selection for the thumb execute core
// depends on tae_pkg
module tae_decode
   import tae_pkg::*;
(
   input  req_type req,
   output dec_type dec
);

   logic [15:0] ins;
   logic [31:0] pc4;
   logic [3:0]  dn, sn;
   logic [31:0] ha, hb, op2, nn;

   always_comb begin
      ins = req.instruction;
      pc4 = req.pc_value + 32'd4;
      dn  = {ins[7], ins[2:0]};
      sn  = {ins[6], ins[5:3]};
      ha  = (dn == PC_REG) ? pc4 : req.rd_value;
      hb  = (sn == PC_REG) ? pc4 : req.rs_value;
      op2 = ins[10] ? {29'd0, ins[8:6]} : req.rn_value;
      nn  = {24'd0, ins[7:0]};
      dec        = '0;
      dec.kind   = K_NONE;
      dec.pc2    = req.pc_value + 32'd2;
      dec.n0     = req.negative_in;
      dec.z0     = req.zero_in;
      dec.c0     = req.carry_in;
      dec.v0     = req.overflow_in;
      dec.dst    = {1'b0, ins[2:0]};
      if (ins[15:11] == 5'b00011) begin
         dec.kind = K_ADD; dec.we = 1'b1; dec.set_nz = 1'b1; dec.set_cv = 1'b1;
         dec.a = req.rs_value;
         dec.b = ins[9] ? ~op2 : op2;
         dec.cin = ins[9];
      end else if (ins[15:13] == 3'b000) begin
         dec.kind = K_SHIFT; dec.we = 1'b1; dec.set_nz = 1'b1;
         dec.a = req.rs_value;
         dec.sop = shift_op_type'(ins[12:11]);
         if (ins[10:6] == 5'd0 && ins[12:11] == 2'd0) dec.amt = 8'd0;
         else if (ins[10:6] == 5'd0) dec.amt = 8'd32;
         else dec.amt = {3'd0, ins[10:6]};
      end else if (ins[15:13] == 3'b001) begin
         dec.dst = {1'b0, ins[10:8]};
         dec.a = req.rd_value; dec.set_nz = 1'b1;
         case (ins[12:11])
            2'd0: begin dec.kind = K_MOVB; dec.b = nn; dec.we = 1'b1; end
            2'd1: begin dec.kind = K_ADD; dec.b = ~nn; dec.cin = 1'b1; dec.set_cv = 1'b1; end
            2'd2: begin dec.kind = K_ADD; dec.b = nn; dec.set_cv = 1'b1; dec.we = 1'b1; end
            default: begin
               dec.kind = K_ADD; dec.b = ~nn; dec.cin = 1'b1; dec.set_cv = 1'b1;
               dec.we = 1'b1;
            end
         endcase
      end else if (ins[15:10] == 6'b010000) begin
         dec.a = req.rd_value; dec.b = req.rs_value; dec.we = 1'b1; dec.set_nz = 1'b1;
         dec.amt = req.rs_value[7:0];
         unique case (ins[9:6]) inside
            ALU_AND, ALU_TST: begin dec.kind = K_LOGIC; dec.lop = LOG_AND; end
            ALU_EOR: begin dec.kind = K_LOGIC; dec.lop = LOG_EOR; end
            ALU_ORR: begin dec.kind = K_LOGIC; dec.lop = LOG_ORR; end
            ALU_BIC: begin dec.kind = K_LOGIC; dec.lop = LOG_BIC; end
            ALU_LSL: begin dec.kind = K_SHIFT; dec.sop = SH_LSL; end
            ALU_LSR: begin dec.kind = K_SHIFT; dec.sop = SH_LSR; end
            ALU_ASR: begin dec.kind = K_SHIFT; dec.sop = SH_ASR; end
            ALU_ROR: begin dec.kind = K_SHIFT; dec.sop = SH_ROR; end
            ALU_ADC, ALU_CMN: begin
               dec.kind = K_ADD; dec.set_cv = 1'b1;
               dec.cin = (ins[9:6] == ALU_ADC) ? req.carry_in : 1'b0;
            end
            ALU_SBC, ALU_CMP: begin
               dec.kind = K_ADD; dec.set_cv = 1'b1; dec.b = ~req.rs_value;
               dec.cin = (ins[9:6] == ALU_SBC) ? req.carry_in : 1'b1;
            end
            ALU_NEG: begin
               dec.kind = K_ADD; dec.set_cv = 1'b1; dec.a = '0;
               dec.b = ~req.rs_value; dec.cin = 1'b1;
            end
            ALU_MUL: dec.kind = K_MUL;
            ALU_MVN: begin dec.kind = K_MOVB; dec.b = ~req.rs_value; end
            default: dec.kind = K_NONE;
         endcase
         if (ins[9:6] == ALU_TST || ins[9:6] == ALU_CMP || ins[9:6] == ALU_CMN) dec.we = 1'b0;
      end else if (ins[15:10] == 6'b010001) begin
         dec.dst = dn; dec.a = ha;
         case (ins[9:8])
            2'd0: begin dec.kind = K_ADD; dec.b = hb; dec.we = 1'b1; end
            2'd1: begin
               dec.kind = K_ADD; dec.b = ~hb; dec.cin = 1'b1;
               dec.set_nz = 1'b1; dec.set_cv = 1'b1;
            end
            2'd2: begin dec.kind = K_MOVB; dec.b = hb; dec.we = 1'b1; end
            default: begin dec.kind = K_BX; dec.b = hb; dec.dst = PC_REG; end
         endcase
      end else if (ins[15:12] == 4'b1010) begin
         dec.kind = K_ADDR; dec.dst = {1'b0, ins[10:8]}; dec.we = 1'b1;
         dec.a = ins[11] ? req.sp_value : {pc4[31:2], 2'b00};
         dec.b = {22'd0, ins[7:0], 2'b00};
      end
   end

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the thumb execute core: directed table then random beats
// depends on tae_pkg and thumb_alu_execute_core
`timescale 1ns / 100ps
module tb_top;
   import tae_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   thumb_alu_execute_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BEATS = 1800;

   typedef struct {
      req_type   stim;
      logic      typed;
      rsp_type   want;
   } row_type;

   rsp_type   expected_q[$];
   int        mismatches;
   int        beats_in;
   int        beats_out;
   int        idle_cycles;
   int        quiet_pct;
   logic      n_f, z_f, c_f, v_f;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] shift_value(input logic [31:0] v, input logic [7:0] amt,
                                               input shift_op_type kind);
      logic [5:0] n;
      if (amt == 8'd0)
         return v;
      case (kind)
         SH_LSL: begin
            if (amt < 8'd32) begin
               c_f = v[32 - amt];
               return v << amt;
            end
            c_f = (amt == 8'd32) ? v[0] : 1'b0;
            return 32'd0;
         end
         SH_LSR: begin
            if (amt < 8'd32) begin
               c_f = v[amt - 1];
               return v >> amt;
            end
            c_f = (amt == 8'd32) ? v[31] : 1'b0;
            return 32'd0;
         end
         SH_ASR: begin
            if (amt < 8'd32) begin
               c_f = v[amt - 1];
               return $signed(v) >>> amt;
            end
            c_f = v[31];
            return {32{v[31]}};
         end
         default: begin
            n = {1'b0, amt[4:0]};
            if (n == 6'd0) begin
               c_f = v[31];
               return v;
            end
            c_f = v[n - 1];
            return (v >> n) | (v << (32 - n));
         end
      endcase
   endfunction

   function automatic logic [31:0] add_nzcv(input logic [31:0] a, input logic [31:0] b,
                                            input logic cin);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      c_f = s[32];
      v_f = (a[31] ^ s[31]) & (b[31] ^ s[31]);
      n_f = s[31];
      z_f = (s[31:0] == 32'd0);
      return s[31:0];
   endfunction

   function automatic rsp_type execute_thumb(input req_type q);
      rsp_type     r;
      logic [15:0] ins;
      logic [31:0] res, a, b, opnd, npc;
      logic [3:0]  dn, sn, op;
      logic [4:0]  off;
      logic        pcw;
      ins = q.instruction;
      res = '0;
      npc = q.pc_value + 32'd2;
      pcw = 1'b0;
      r = '0;
      c_f = q.carry_in; v_f = q.overflow_in; n_f = q.negative_in; z_f = q.zero_in;
      if (ins[15:11] == 5'b00011) begin
         opnd = ins[10] ? {29'd0, ins[8:6]} : q.rn_value;
         r.dest_reg = {1'b0, ins[2:0]}; r.write_en = 1'b1;
         res = ins[9] ? add_nzcv(q.rs_value, ~opnd, 1'b1) : add_nzcv(q.rs_value, opnd, 1'b0);
      end else if (ins[15:13] == 3'b000) begin
         off = ins[10:6];
         r.dest_reg = {1'b0, ins[2:0]}; r.write_en = 1'b1;
         if (off == 5'd0 && ins[12:11] == 2'd0)
            res = q.rs_value;
         else
            res = shift_value(q.rs_value, (off == 5'd0) ? 8'd32 : {3'd0, off},
                              shift_op_type'(ins[12:11]));
         n_f = res[31]; z_f = (res == 32'd0);
      end else if (ins[15:13] == 3'b001) begin
         r.dest_reg = {1'b0, ins[10:8]};
         case (ins[12:11])
            2'd0: begin
               res = {24'd0, ins[7:0]}; n_f = 1'b0; z_f = (res == 32'd0); r.write_en = 1'b1;
            end
            2'd1: res = add_nzcv(q.rd_value, ~{24'd0, ins[7:0]}, 1'b1);
            2'd2: begin
               res = add_nzcv(q.rd_value, {24'd0, ins[7:0]}, 1'b0); r.write_en = 1'b1;
            end
            default: begin
               res = add_nzcv(q.rd_value, ~{24'd0, ins[7:0]}, 1'b1); r.write_en = 1'b1;
            end
         endcase
      end else if (ins[15:10] == 6'b010000) begin
         op = ins[9:6];
         r.dest_reg = {1'b0, ins[2:0]}; r.write_en = 1'b1;
         case (op)
            ALU_AND: res = q.rd_value & q.rs_value;
            ALU_EOR: res = q.rd_value ^ q.rs_value;
            ALU_LSL: res = shift_value(q.rd_value, q.rs_value[7:0], SH_LSL);
            ALU_LSR: res = shift_value(q.rd_value, q.rs_value[7:0], SH_LSR);
            ALU_ASR: res = shift_value(q.rd_value, q.rs_value[7:0], SH_ASR);
            ALU_ADC: res = add_nzcv(q.rd_value, q.rs_value, q.carry_in);
            ALU_SBC: res = add_nzcv(q.rd_value, ~q.rs_value, q.carry_in);
            ALU_ROR: res = shift_value(q.rd_value, q.rs_value[7:0], SH_ROR);
            ALU_TST: begin
               res = q.rd_value & q.rs_value; r.write_en = 1'b0;
            end
            ALU_NEG: res = add_nzcv(32'd0, ~q.rs_value, 1'b1);
            ALU_CMP: begin
               res = add_nzcv(q.rd_value, ~q.rs_value, 1'b1); r.write_en = 1'b0;
            end
            ALU_CMN: begin
               res = add_nzcv(q.rd_value, q.rs_value, 1'b0); r.write_en = 1'b0;
            end
            ALU_ORR: res = q.rd_value | q.rs_value;
            ALU_MUL: res = q.rd_value * q.rs_value;
            ALU_BIC: res = q.rd_value & ~q.rs_value;
            default: res = ~q.rs_value;
         endcase
         n_f = res[31]; z_f = (res == 32'd0);
      end else if (ins[15:10] == 6'b010001) begin
         dn = {ins[7], ins[2:0]};
         sn = {ins[6], ins[5:3]};
         a = (dn == PC_REG) ? q.pc_value + 32'd4 : q.rd_value;
         b = (sn == PC_REG) ? q.pc_value + 32'd4 : q.rs_value;
         r.dest_reg = dn;
         case (ins[9:8])
            2'd0: begin
               res = a + b; r.write_en = 1'b1;
            end
            2'd1: res = add_nzcv(a, ~b, 1'b1);
            2'd2: begin
               res = b; r.write_en = 1'b1;
            end
            default: begin
               r.dest_reg = PC_REG;
               res = {b[31:1], 1'b0};
               r.enter_arm_state = ~b[0];
               npc = res;
            end
         endcase
         pcw = r.write_en && dn == PC_REG;
      end else if (ins[15:12] == 4'hA) begin
         r.dest_reg = {1'b0, ins[10:8]}; r.write_en = 1'b1;
         res = ins[11] ? q.sp_value + {22'd0, ins[7:0], 2'b00}
                       : ((q.pc_value + 32'd4) & ~32'd3) + {22'd0, ins[7:0], 2'b00};
      end else begin
         r.not_handled = 1'b1;
      end
      if (pcw)
         npc = {res[31:1], 1'b0};
      r.result_value = res;
      r.next_pc = npc;
      r.negative_out = n_f; r.zero_out = z_f; r.carry_out = c_f; r.overflow_out = v_f;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at beat %0d: %s got %h want %h", beats_out, what, got, want);
      mismatches++;
   endtask

   // response side: ready throttling and checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= quiet_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_data.result_value, 32'd0);
            end else begin
               rsp_type w;
               w = expected_q.pop_front();
               if (rsp_data.result_value !== w.result_value)
                  report_mismatch("result_value", rsp_data.result_value, w.result_value);
               if (rsp_data.dest_reg !== w.dest_reg)
                  report_mismatch("dest_reg", 32'(rsp_data.dest_reg), 32'(w.dest_reg));
               if (rsp_data.write_en !== w.write_en)
                  report_mismatch("write_en", 32'(rsp_data.write_en), 32'(w.write_en));
               if (rsp_data.negative_out !== w.negative_out)
                  report_mismatch("negative_out", 32'(rsp_data.negative_out),
                                  32'(w.negative_out));
               if (rsp_data.zero_out !== w.zero_out)
                  report_mismatch("zero_out", 32'(rsp_data.zero_out), 32'(w.zero_out));
               if (rsp_data.carry_out !== w.carry_out)
                  report_mismatch("carry_out", 32'(rsp_data.carry_out), 32'(w.carry_out));
               if (rsp_data.overflow_out !== w.overflow_out)
                  report_mismatch("overflow_out", 32'(rsp_data.overflow_out),
                                  32'(w.overflow_out));
               if (rsp_data.enter_arm_state !== w.enter_arm_state)
                  report_mismatch("enter_arm_state", 32'(rsp_data.enter_arm_state),
                                  32'(w.enter_arm_state));
               if (rsp_data.next_pc !== w.next_pc)
                  report_mismatch("next_pc", rsp_data.next_pc, w.next_pc);
               if (rsp_data.not_handled !== w.not_handled)
                  report_mismatch("not_handled", 32'(rsp_data.not_handled),
                                  32'(w.not_handled));
            end
            beats_out++;
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d beats outstanding", expected_q.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] pick_instruction();
      logic [15:0] ins;
      ins = 16'($urandom);
      case ($urandom_range(9)) inside
         0: ins[15:11] = 5'b00011;
         1: ins[15:13] = 3'b000;
         2: ins[15:13] = 3'b001;
         3, 4: ins[15:10] = 6'b010000;
         5, 6: ins[15:10] = 6'b010001;
         7: ins[15:12] = 4'hA;
         default: ;
      endcase
      return ins;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(40);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type pick_request();
      req_type q;
      q.instruction = pick_instruction();
      q.rs_value = pick_word();
      q.rd_value = pick_word();
      q.rn_value = pick_word();
      q.pc_value = $urandom;
      q.sp_value = $urandom;
      {q.carry_in, q.overflow_in, q.negative_in, q.zero_in} = 4'($urandom);
      return q;
   endfunction

   task automatic send_beat(input req_type q, input rsp_type want);
      while ($urandom_range(99) < quiet_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do
         @(posedge clock);
      while (!req_ready);
      expected_q.push_back(want);
      beats_in++;
   endtask

   function automatic req_type make_req(input logic [15:0] ins, input logic [31:0] rs,
                                        input logic [31:0] rd, input logic [3:0] flags);
      req_type q;
      q.instruction = ins;
      q.rs_value = rs;
      q.rd_value = rd;
      q.rn_value = 32'h0000_0003;
      q.pc_value = 32'h0000_1000;
      q.sp_value = 32'h0000_8000;
      {q.carry_in, q.overflow_in, q.negative_in, q.zero_in} = flags;
      return q;
   endfunction

   initial begin
      row_type table_rows[$];
      row_type row;
      req_type q;
      rsp_type w;
      int      k;
      mismatches = 0; beats_in = 0; beats_out = 0;
      quiet_pct = 25;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows; typed where obvious
      row.typed = 1'b1;
      row.stim = make_req(16'hDF00, 32'd0, 32'd0, 4'b1010);
      row.want = '0;
      row.want.not_handled = 1'b1; row.want.next_pc = 32'h0000_1002;
      {row.want.carry_out, row.want.overflow_out, row.want.negative_out,
       row.want.zero_out} = 4'b1010;
      table_rows.push_back(row);
      row.stim = make_req(16'h2000, 32'd0, 32'd0, 4'b0000);
      row.want = '0;
      row.want.write_en = 1'b1; row.want.zero_out = 1'b1; row.want.next_pc = 32'h0000_1002;
      table_rows.push_back(row);
      row.stim = make_req(16'h4770, 32'h0000_2001, 32'd0, 4'b0000);
      row.want = '0;
      row.want.result_value = 32'h0000_2000; row.want.dest_reg = PC_REG;
      row.want.next_pc = 32'h0000_2000;
      table_rows.push_back(row);
      row.typed = 1'b0;
      for (k = 0; k < 16; k++) begin
         row.stim = make_req({6'b010000, k[3:0], 6'b001001}, 32'hFFFF_FFFF,
                             32'h8000_0000, k[3:0]);
         table_rows.push_back(row);
      end
      row.stim = make_req(16'h0000, 32'hFFFF_FFFF, 32'd0, 4'b1111); table_rows.push_back(row);
      row.stim = make_req(16'h0800, 32'h8000_0000, 32'd0, 4'b0000); table_rows.push_back(row);
      row.stim = make_req(16'h1000, 32'h8000_0001, 32'd0, 4'b0000); table_rows.push_back(row);
      row.stim = make_req(16'h1FC9, 32'h7FFF_FFFF, 32'd0, 4'b0000); table_rows.push_back(row);
      row.stim = make_req(16'h44FF, 32'd0, 32'd0, 4'b0000); table_rows.push_back(row);
      row.stim = make_req(16'h46F7, 32'h0000_0005, 32'd0, 4'b0000); table_rows.push_back(row);
      row.stim = make_req(16'hA7FF, 32'd0, 32'd0, 4'b0000); table_rows.push_back(row);
      row.stim = make_req(16'hAFFF, 32'd0, 32'd0, 4'b0000); table_rows.push_back(row);

      foreach (table_rows[i])
         send_beat(table_rows[i].stim,
                   table_rows[i].typed ? table_rows[i].want
                                       : execute_thumb(table_rows[i].stim));

      for (k = 0; k < RANDOM_BEATS; k++) begin
         quiet_pct = (k >= 600 && k < 900) ? 0 : 25;
         q = pick_request();
         w = execute_thumb(q);
         send_beat(q, w);
      end
      req_valid <= 1'b0;
      quiet_pct = 25;

      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d directed and %0d random instructions, %0d sent, %0d checked",
               table_rows.size(), RANDOM_BEATS, beats_in, beats_out);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
